@@ rtl/core/fnv1k_pkg.sv @@
// ----------------------------------------------------------------------------
// fnv1k_pkg
// Shared constants and arithmetic for the 1024-bit FNV-1a byte hash.
// ----------------------------------------------------------------------------
package fnv1k_pkg;

    localparam int FNV_WORD_W = 64;
    localparam int FNV_WORDS  = 16;
    localparam int FNV_BITS   = FNV_WORD_W * FNV_WORDS;
    localparam int FNV_IDX_W  = 4;
    localparam int FNV_BYTE_W = 8;

    // Stream payload widths, padded to whole bytes.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 72;

    // The prime is 2^680 + 0x18d; 0x18d has bits 0, 2, 3, 7 and 8 set.
    localparam int FNV_PRIME_HIGH = 680;

    typedef logic [FNV_BITS-1:0]   fnv_hash_t;
    typedef logic [FNV_WORD_W-1:0] fnv_word_t;
    typedef logic [FNV_IDX_W-1:0]  fnv_idx_t;

    typedef struct packed {
        logic busy;       // a digest is being sent
        logic last_out;   // the final word of the digest leaves this cycle
    } fnv_dig_status_t;

    localparam fnv_hash_t FNV_BASIS = {
        64'h0000000000000000, 64'h005f7a76758ecc4d,
        64'h32e56d5a591028b7, 64'h4b29fc4223fdada1,
        64'h6c3bf34eda3674da, 64'h9a21d90000000000,
        64'h0000000000000000, 64'h0000000000000000,
        64'h0000000000000000, 64'h0000000000000000,
        64'h0000000000000000, 64'h000000000004c6d7,
        64'heb6e73802734510a, 64'h555f256cc005ae55,
        64'h6bde8cc9c6a93b21, 64'haff4b16c71ee90b3
    };

    typedef struct packed {
        fnv_hash_t sum;
        fnv_hash_t carry;
    } fnv_csa_t;

    // Carry-save adder over three 1024-bit operands, truncated mod 2^1024.
    function automatic fnv_csa_t fnv_csa(input fnv_hash_t a, input fnv_hash_t b,
                                         input fnv_hash_t c);
        fnv_csa_t r;
        r.sum   = a ^ b ^ c;
        r.carry = ((a & b) | (a & c) | (b & c)) << 1;
        return r;
    endfunction

    // x * (2^680 + 0x18d) mod 2^1024: six shifted terms reduced by a
    // carry-save tree to two vectors, then a single wide add.
    function automatic fnv_hash_t fnv_mul_prime(input fnv_hash_t x);
        fnv_csa_t l0a;
        fnv_csa_t l0b;
        fnv_csa_t l1;
        fnv_csa_t l2;
        l0a = fnv_csa(x, x << 2, x << 3);
        l0b = fnv_csa(x << 7, x << 8, x << FNV_PRIME_HIGH);
        l1  = fnv_csa(l0a.sum, l0a.carry, l0b.sum);
        l2  = fnv_csa(l1.sum, l1.carry, l0b.carry);
        return l2.sum + l2.carry;
    endfunction

endpackage

@@ rtl/core/fnv1a_1024_byte_hash_top.sv @@
// ----------------------------------------------------------------------------
// fnv1a_1024_byte_hash_top
// 1024-bit FNV-1a hash over a byte stream with a word-serial digest output.
//
//   Channel  Direction  Beat contents
//   s_*      in         tdata[7:0] data_byte, tuser start_hash, tlast last_byte
//   m_*      out        tdata[63:0] digest_word, tdata[67:64] word_index,
//                       tlast final_word
//
// One byte is folded per clock while s_tready is high; the xor, carry-save
// tree and one 1024-bit add sit between the state register and itself.
// A byte marked last loads the digest buffer, which then sends 16 beats.
// Bytes without tlast keep flowing during a digest; a second tlast byte is
// held off until the last word of the pending digest is taken.
// Reset loads the offset basis into the state and idles the digest buffer.
// ----------------------------------------------------------------------------
module fnv1a_1024_byte_hash_top
    import fnv1k_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic                 s_tuser,   // start_hash
    input  logic                 s_tlast,   // last_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [63:0] digest_word, [67:64] word_index
    output logic                 m_tlast    // final_word
);

    fnv_dig_status_t dig_status;
    fnv_hash_t       hash_next;
    fnv_word_t       digest_word;
    fnv_idx_t        word_index;
    logic            in_beat;

    assign s_tready = ~s_tlast | ~dig_status.busy | dig_status.last_out;
    assign in_beat  = s_tvalid & s_tready;

    fnv1k_state u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (in_beat),
        .restart   (s_tuser),
        .data_byte (s_tdata[FNV_BYTE_W-1:0]),
        .hash_next (hash_next)
    );

    fnv1k_digest u_digest (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (in_beat & s_tlast),
        .hash        (hash_next),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .digest_word (digest_word),
        .word_index  (word_index),
        .final_word  (m_tlast),
        .status      (dig_status)
    );

    assign m_tdata = {{(M_TDATA_W - FNV_WORD_W - FNV_IDX_W){1'b0}}, word_index, digest_word};

endmodule

@@ rtl/core/fnv1k_state.sv @@
// ----------------------------------------------------------------------------
// fnv1k_state
// Hash state register and the per-byte xor-and-multiply update.
// ----------------------------------------------------------------------------
module fnv1k_state
    import fnv1k_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  restart,
    input  logic [FNV_BYTE_W-1:0] data_byte,
    output fnv_hash_t             hash_next
);

    fnv_hash_t state_reg;
    fnv_hash_t base;

    always_comb
    begin
        base = restart ? FNV_BASIS : state_reg;
        base[FNV_BYTE_W-1:0] = base[FNV_BYTE_W-1:0] ^ data_byte;
        hash_next = fnv_mul_prime(base);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FNV_BASIS;
        end
        else if (step)
        begin
            state_reg <= hash_next;
        end
    end

endmodule

@@ rtl/core/fnv1k_digest.sv @@
// ----------------------------------------------------------------------------
// fnv1k_digest
// Holds a finished hash and sends it as sixteen 64-bit words, low word first.
// ----------------------------------------------------------------------------
module fnv1k_digest
    import fnv1k_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  fnv_hash_t       hash,
    input  logic            m_tready,
    output logic            m_tvalid,
    output fnv_word_t       digest_word,
    output fnv_idx_t        word_index,
    output logic            final_word,
    output fnv_dig_status_t status
);

    localparam fnv_idx_t LAST_IDX = FNV_IDX_W'(FNV_WORDS - 1);

    fnv_hash_t buf_reg;
    fnv_hash_t buf_next;
    fnv_idx_t  idx_reg;
    fnv_idx_t  idx_next;
    logic      busy_reg;
    logic      busy_next;
    logic      beat;

    assign beat        = busy_reg & m_tready;
    assign m_tvalid    = busy_reg;
    assign digest_word = buf_reg[FNV_WORD_W-1:0];
    assign word_index  = idx_reg;
    assign final_word  = (idx_reg == LAST_IDX);

    assign status.busy     = busy_reg;
    assign status.last_out = beat & final_word;

    always_comb
    begin
        buf_next  = buf_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (beat)
        begin
            buf_next = buf_reg >> FNV_WORD_W;
            idx_next = idx_reg + fnv_idx_t'(1);
            if (final_word)
            begin
                busy_next = 1'b0;
            end
        end
        // A new digest may load in the same cycle the previous one finishes.
        if (load)
        begin
            buf_next  = hash;
            idx_next  = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the 1024-bit FNV-1a byte hash. Bytes go in as beats
// with random gaps. A local model folds each accepted byte into its own
// 1024-bit hash and queues the sixteen digest words that a last byte must
// produce. A monitor compares every output beat against that queue while the
// receiver stalls at random.
// ----------------------------------------------------------------------------
module testbench;
    import fnv1k_pkg::*;

    localparam logic [8:0] PRIME_LOW_PART = 9'h18d;
    localparam int         SETTLE_CYCLES  = 40;
    localparam int         RANDOM_BYTES   = 150;

    typedef struct {
        fnv_word_t word;
        fnv_idx_t  idx;
        logic      fin;
    } digest_beat_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [7:0] data_byte
    logic                 s_tuser;   // start_hash
    logic                 s_tlast;   // last_byte
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;   // [63:0] digest_word, [67:64] word_index
    logic                 m_tlast;   // final_word

    fnv_hash_t    running_hash;
    digest_beat_t digest_beats_q[$];
    int           failures;
    int           bytes_sent;
    int           stall_left;
    bit           no_idle;

    fnv1a_1024_byte_hash_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    // XOR the byte into the low bits, then multiply by 2^680 + 0x18d mod 2^1024.
    function automatic fnv_hash_t fold_byte(input fnv_hash_t h, input logic [7:0] b);
        fnv_hash_t x;
        x = h ^ fnv_hash_t'(b);
        return (x << FNV_PRIME_HIGH) + x * fnv_hash_t'(PRIME_LOW_PART);
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Called at a falling edge; returns at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic start, input logic last);
        int gap;
        int k;
        digest_beat_t beat;
        s_tdata  <= b;
        s_tuser  <= start;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
        if (start)
            running_hash = FNV_BASIS;
        running_hash = fold_byte(running_hash, b);
        if (last)
        begin
            for (k = 0; k < FNV_WORDS; k++)
            begin
                beat.word = running_hash[k*FNV_WORD_W +: FNV_WORD_W];
                beat.idx  = fnv_idx_t'(k);
                beat.fin  = (k == FNV_WORDS - 1);
                digest_beats_q.push_back(beat);
            end
        end
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic wait_for_digests();
        s_tvalid <= 1'b0;
        while (digest_beats_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_message(input int len);
        int i;
        for (i = 0; i < len; i++)
            send_byte(8'($urandom), i == 0, i == len - 1);
    endtask

    // Extreme bytes, bytes before any start, continuing after a digest,
    // one-byte messages and a restart in the middle of a message.
    task automatic test_directed();
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hff, 1'b0, 1'b1);
        send_byte(8'h5a, 1'b0, 1'b1);
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hff, 1'b1, 1'b1);
        send_byte(8'h80, 1'b1, 1'b1);
        send_byte(8'h01, 1'b1, 1'b1);
        send_byte(8'h61, 1'b1, 1'b0);
        send_byte(8'h62, 1'b0, 1'b0);
        send_byte(8'h63, 1'b0, 1'b1);
        send_byte(8'h33, 1'b1, 1'b0);
        send_byte(8'hcc, 1'b1, 1'b0);
        send_byte(8'haa, 1'b0, 1'b0);
        send_byte(8'h55, 1'b0, 1'b1);
        send_byte(8'h7f, 1'b0, 1'b0);
        send_byte(8'hfe, 1'b0, 1'b1);
    endtask

    // Full speed on both sides: the second last byte has to wait for the
    // pending digest to drain.
    task automatic test_back_to_back();
        int i;
        no_idle = 1'b1;
        for (i = 0; i < 4; i++)
            send_byte(8'($urandom), 1'b1, 1'b1);
        send_message(3);
        send_message(2);
        no_idle = 1'b0;
    endtask

    // The sender holds off until the whole digest is out, then resumes the
    // same hash without a start.
    task automatic test_hold_off();
        send_message(5);
        wait_for_digests();
        send_byte(8'($urandom), 1'b0, 1'b0);
        send_byte(8'($urandom), 1'b0, 1'b1);
    endtask

    // Mostly well-formed messages with random content, some stray beats.
    task automatic test_random_messages(input int target);
        int r;
        while (bytes_sent < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                send_message($urandom_range(9, 24));
            else if (r < 85)
                send_message($urandom_range(1, 6));
            else
                send_byte(8'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!no_idle && $urandom_range(0, 99) < 25)
                stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        digest_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (digest_beats_q.size() == 0)
            begin
                $error("unexpected digest beat: tdata=%h tlast=%b", m_tdata, m_tlast);
                failures++;
            end
            else
            begin
                want = digest_beats_q.pop_front();
                if (m_tdata[63:0] !== want.word)
                begin
                    $error("digest_word: expected %h, got %h", want.word, m_tdata[63:0]);
                    failures++;
                end
                if (m_tdata[67:64] !== want.idx)
                begin
                    $error("word_index: expected %0d, got %0d", want.idx, m_tdata[67:64]);
                    failures++;
                end
                if (m_tlast !== want.fin)
                begin
                    $error("final_word: expected %b, got %b", want.fin, m_tlast);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        failures     = 0;
        bytes_sent   = 0;
        stall_left   = 0;
        no_idle      = 1'b0;
        running_hash = FNV_BASIS;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        s_tlast      = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_back_to_back();
        test_hold_off();
        test_random_messages(bytes_sent + RANDOM_BYTES);
        // Close any message left open so its bytes still reach a digest.
        send_byte(8'($urandom), 1'b0, 1'b1);

        wait_for_digests();
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
